### rtl/core/sse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and codes for the silhouette edge extractor: request kinds,
// configuration register indexes and the stored point layout.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgAddrW = 2;

  // request kinds
  localparam logic [KindW-1:0] KIND_FACE  = 2'd0;
  localparam logic [KindW-1:0] KIND_POINT = 2'd1;
  localparam logic [KindW-1:0] KIND_EDGE  = 2'd2;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_LIGHT_X = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_LIGHT_Z = 2'd2;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

endpackage

### rtl/core/silhouette_edge_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silhouette_edge_extractor
// Light-facing test of mesh faces and silhouette edge output for shadow volumes.
// ----------------------------------------------------------------------------
// Usage: write light_x/y/z through cfg_we_i/cfg_addr_i/cfg_wdata_i while idle,
// then stream requests with start_i (busy_o stays low, so one request is taken
// every cycle). A face request stores whether normal . light is positive, a
// point request stores its coordinates, and an edge request reads two faces
// and two points.
// Result: an edge whose faces differ in lit state shows its oriented
// endpoints on the start and end outputs with edge_valid_o high for one cycle,
// via the stage 1 and result registers. Other requests produce no result.
// Throughput: one request per cycle. A face flag is written in the cycle after
// its request (products are registered first); an edge right behind a face
// load picks the fresh flag up over a bypass path.
// Reset clears the light registers and the pipeline; face and point stores
// are not cleared and must be loaded before edges read them.
// The receiver cannot stall: each result is present for exactly one cycle.
// ----------------------------------------------------------------------------
module silhouette_edge_extractor #(
  parameter int unsigned MAX_FACES  = 256,
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sse_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [sse_pkg::CoordW-1:0]        cfg_wdata_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [sse_pkg::KindW-1:0]         kind_i,
  input  logic [sse_pkg::IdxW-1:0]          slot_i,
  input  logic signed [sse_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [sse_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [sse_pkg::CoordW-1:0] coord_z_i,
  input  logic [sse_pkg::IdxW-1:0]          face_a_i,
  input  logic [sse_pkg::IdxW-1:0]          face_b_i,
  input  logic [sse_pkg::IdxW-1:0]          point_a_i,
  input  logic [sse_pkg::IdxW-1:0]          point_b_i,
  output logic                              edge_valid_o,
  output logic signed [sse_pkg::CoordW-1:0] start_x_o,
  output logic signed [sse_pkg::CoordW-1:0] start_y_o,
  output logic signed [sse_pkg::CoordW-1:0] start_z_o,
  output logic signed [sse_pkg::CoordW-1:0] end_x_o,
  output logic signed [sse_pkg::CoordW-1:0] end_y_o,
  output logic signed [sse_pkg::CoordW-1:0] end_z_o
);

  localparam int unsigned IdxSpan    = 2 ** sse_pkg::IdxW;
  localparam int unsigned FACE_DEPTH = (MAX_FACES < IdxSpan) ? MAX_FACES : IdxSpan;
  localparam int unsigned PT_DEPTH   = (MAX_POINTS < IdxSpan) ? MAX_POINTS : IdxSpan;
  localparam int unsigned FACE_AW    = $clog2(FACE_DEPTH);
  localparam int unsigned PT_AW      = $clog2(PT_DEPTH);
  localparam int unsigned ProdW      = 2 * sse_pkg::CoordW;
  localparam int unsigned SumW       = ProdW + 2;

  // configuration
  sse_pkg::coord_t light_x_q, light_y_q, light_z_q;

  // stores
  logic            face_mem [FACE_DEPTH];
  sse_pkg::point_t point_mem [PT_DEPTH];

  // input acceptance
  logic accept;
  logic slot_face_ok, slot_pt_ok;
  logic fa_ok, fb_ok, pa_ok, pb_ok;

  // stage 1
  logic                   s1_face_q, s1_edge_q;
  logic [sse_pkg::IdxW-1:0] s1_slot_q;
  logic signed [ProdW-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic                   fa_mem_q, fb_mem_q;
  logic                   fa_ok_q, fb_ok_q, pa_ok_q, pb_ok_q;
  logic                   fa_byp_q, fb_byp_q, lit_byp_q;
  sse_pkg::point_t        pa_q, pb_q;

  // stage 1 logic
  logic signed [SumW-1:0] dot_sum;
  logic                   lit_now;
  logic                   lit_a, lit_b;
  sse_pkg::point_t        pa_eff, pb_eff;
  logic                   emit;

  // result register
  logic            valid_q;
  sse_pkg::point_t start_q, end_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign slot_face_ok = 32'(slot_i) < FACE_DEPTH;
  assign slot_pt_ok   = 32'(slot_i) < PT_DEPTH;
  assign fa_ok = 32'(face_a_i) < FACE_DEPTH;
  assign fb_ok = 32'(face_b_i) < FACE_DEPTH;
  assign pa_ok = 32'(point_a_i) < PT_DEPTH;
  assign pb_ok = 32'(point_b_i) < PT_DEPTH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q <= '0;
      light_y_q <= '0;
      light_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sse_pkg::REG_LIGHT_X: light_x_q <= cfg_wdata_i;
        sse_pkg::REG_LIGHT_Y: light_y_q <= cfg_wdata_i;
        sse_pkg::REG_LIGHT_Z: light_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // exact 66-bit dot product, lit when strictly positive
  assign dot_sum = SumW'(prod_x_q) + SumW'(prod_y_q) + SumW'(prod_z_q);
  assign lit_now = !dot_sum[SumW-1] && (dot_sum != '0);

  // face flag store: written in the cycle after the face request
  always_ff @(posedge clk_i) begin
    if (s1_face_q) begin
      face_mem[s1_slot_q[FACE_AW-1:0]] <= lit_now;
    end
    fa_mem_q <= face_mem[face_a_i[FACE_AW-1:0]];
    fb_mem_q <= face_mem[face_b_i[FACE_AW-1:0]];
  end

  // point store: written on acceptance, read-before-write
  always_ff @(posedge clk_i) begin
    if (accept && kind_i == sse_pkg::KIND_POINT && slot_pt_ok) begin
      point_mem[slot_i[PT_AW-1:0]] <= '{x: coord_x_i, y: coord_y_i, z: coord_z_i};
    end
    pa_q <= point_mem[point_a_i[PT_AW-1:0]];
    pb_q <= point_mem[point_b_i[PT_AW-1:0]];
  end

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_face_q <= 1'b0;
      s1_edge_q <= 1'b0;
    end else begin
      s1_face_q <= accept && kind_i == sse_pkg::KIND_FACE && slot_face_ok;
      s1_edge_q <= accept && kind_i == sse_pkg::KIND_EDGE;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    s1_slot_q <= slot_i;
    prod_x_q  <= coord_x_i * light_x_q;
    prod_y_q  <= coord_y_i * light_y_q;
    prod_z_q  <= coord_z_i * light_z_q;
    fa_ok_q   <= fa_ok;
    fb_ok_q   <= fb_ok;
    pa_ok_q   <= pa_ok;
    pb_ok_q   <= pb_ok;
    // face flag still in flight to the store
    fa_byp_q  <= s1_face_q && (s1_slot_q == face_a_i);
    fb_byp_q  <= s1_face_q && (s1_slot_q == face_b_i);
    lit_byp_q <= lit_now;
  end

  assign lit_a  = fa_ok_q && (fa_byp_q ? lit_byp_q : fa_mem_q);
  assign lit_b  = fb_ok_q && (fb_byp_q ? lit_byp_q : fb_mem_q);
  assign pa_eff = pa_ok_q ? pa_q : '0;
  assign pb_eff = pb_ok_q ? pb_q : '0;
  assign emit   = s1_edge_q && (lit_a ^ lit_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit;
    end
  end

  // unlit-to-lit orientation
  always_ff @(posedge clk_i) begin
    if (emit) begin
      start_q <= lit_b ? pa_eff : pb_eff;
      end_q   <= lit_b ? pb_eff : pa_eff;
    end
  end

  assign edge_valid_o = valid_q;
  assign start_x_o    = start_q.x;
  assign start_y_o    = start_q.y;
  assign start_z_o    = start_q.z;
  assign end_x_o      = end_q.x;
  assign end_y_o      = end_q.y;
  assign end_z_o      = end_q.z;

`ifndef SYNTHESIS
  a_result_from_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_valid_o |-> $past(s1_edge_q))
    else $error("result without an edge request");

  a_differing_faces_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_edge_q && (lit_a != lit_b)) |=> edge_valid_o)
    else $error("silhouette edge dropped");

  a_equal_faces_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_edge_q && (lit_a != lit_b)) |=> !edge_valid_o)
    else $error("spurious silhouette edge");

  a_bypass_only_behind_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fa_byp_q || fb_byp_q) |-> $past(s1_face_q))
    else $error("face bypass without a pending face write");
`endif

endmodule

### test/edge_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_scoreboard
// Watches the configuration port, the request channel and the edge output of
// the silhouette edge extractor. It keeps its own light position, lit flags
// and point table, predicts the oriented edge of each accepted edge request
// whose faces differ in lit state and compares each emitted edge with the oldest prediction.
// ----------------------------------------------------------------------------
module edge_scoreboard (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sse_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [sse_pkg::CoordW-1:0]   cfg_wdata_i,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [sse_pkg::KindW-1:0]    kind_i,
  input  logic [sse_pkg::IdxW-1:0]     slot_i,
  input  sse_pkg::coord_t              coord_x_i,
  input  sse_pkg::coord_t              coord_y_i,
  input  sse_pkg::coord_t              coord_z_i,
  input  logic [sse_pkg::IdxW-1:0]     face_a_i,
  input  logic [sse_pkg::IdxW-1:0]     face_b_i,
  input  logic [sse_pkg::IdxW-1:0]     point_a_i,
  input  logic [sse_pkg::IdxW-1:0]     point_b_i,
  input  logic                         edge_valid_i,
  input  sse_pkg::coord_t              start_x_i,
  input  sse_pkg::coord_t              start_y_i,
  input  sse_pkg::coord_t              start_z_i,
  input  sse_pkg::coord_t              end_x_i,
  input  sse_pkg::coord_t              end_y_i,
  input  sse_pkg::coord_t              end_z_i,
  output int                           errors_o,
  output int                           outstanding_o
);

  typedef struct packed {
    sse_pkg::point_t start_pt;
    sse_pkg::point_t end_pt;
  } sil_edge_t;

  sse_pkg::coord_t light_x, light_y, light_z;
  logic            face_lit [256];
  sse_pkg::point_t points [256];
  sil_edge_t       edge_q [$];
  sil_edge_t       want;
  sil_edge_t       pred;
  logic            lit_a, lit_b;
  int              errors = 0;

  assign errors_o = errors;

  // exact 66-bit dot product, lit only when strictly positive
  function automatic logic faces_light(sse_pkg::coord_t nx, sse_pkg::coord_t ny,
                                       sse_pkg::coord_t nz);
    logic signed [65:0] ax, ay, az, dot;
    ax  = nx;
    ay  = ny;
    az  = nz;
    dot = ax * light_x + ay * light_y + az * light_z;
    return dot > 0;
  endfunction

  task automatic report(string msg);
    errors++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_coord(string what, sse_pkg::coord_t exp_v, sse_pkg::coord_t got_v);
    if (exp_v !== got_v) begin
      report($sformatf("%s mismatch: expected %0d got %0d", what, exp_v, got_v));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x = '0;
      light_y = '0;
      light_z = '0;
      edge_q.delete();
      outstanding_o <= 0;
    end else begin
      if (edge_valid_i) begin
        if (edge_q.size() == 0) begin
          report($sformatf("edge with no request waiting: (%0d,%0d,%0d)->(%0d,%0d,%0d)",
                           start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i));
        end else begin
          want = edge_q.pop_front();
          check_coord("start_x", want.start_pt.x, start_x_i);
          check_coord("start_y", want.start_pt.y, start_y_i);
          check_coord("start_z", want.start_pt.z, start_z_i);
          check_coord("end_x", want.end_pt.x, end_x_i);
          check_coord("end_y", want.end_pt.y, end_y_i);
          check_coord("end_z", want.end_pt.z, end_z_i);
        end
      end

      if (cfg_we_i) begin
        case (cfg_addr_i)
          sse_pkg::REG_LIGHT_X: light_x = cfg_wdata_i;
          sse_pkg::REG_LIGHT_Y: light_y = cfg_wdata_i;
          sse_pkg::REG_LIGHT_Z: light_z = cfg_wdata_i;
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        case (kind_i)
          sse_pkg::KIND_FACE: begin
            face_lit[slot_i] = faces_light(coord_x_i, coord_y_i, coord_z_i);
          end
          sse_pkg::KIND_POINT: points[slot_i] = {coord_x_i, coord_y_i, coord_z_i};
          sse_pkg::KIND_EDGE: begin
            lit_a = face_lit[face_a_i];
            lit_b = face_lit[face_b_i];
            // keep the unlit-to-lit direction
            if (!lit_a && lit_b) begin
              pred   = {points[point_a_i], points[point_b_i]};
              edge_q = {edge_q, pred};
            end else if (lit_a && !lit_b) begin
              pred   = {points[point_b_i], points[point_a_i]};
              edge_q = {edge_q, pred};
            end
          end
          default: ;
        endcase
      end

      outstanding_o <= edge_q.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the silhouette edge extractor: a directed set of face, point
// and edge requests at the numeric extremes, then random meshes streamed under
// several light positions and sender idle rates. The scoreboard does the
// prediction and checking; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [sse_pkg::KindW-1:0] KIND_SPARE = 2'd3;
  localparam sse_pkg::coord_t CMIN = 32'sh8000_0000;
  localparam sse_pkg::coord_t CMAX = 32'sh7fff_ffff;
  localparam int              ReqPerPhase = 185;

  typedef logic [sse_pkg::IdxW-1:0] idx_t;

  typedef struct {
    logic [sse_pkg::KindW-1:0] kind;
    idx_t                      slot;
    sse_pkg::coord_t           x, y, z;
    idx_t                      fa, fb, pa, pb;
  } geom_req_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [sse_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [sse_pkg::CoordW-1:0]   cfg_wdata = '0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [sse_pkg::KindW-1:0]    kind = '0;
  idx_t                         slot = '0;
  sse_pkg::coord_t              coord_x = '0, coord_y = '0, coord_z = '0;
  idx_t                         face_a = '0, face_b = '0, point_a = '0, point_b = '0;
  logic                         edge_valid;
  sse_pkg::coord_t              start_x, start_y, start_z, end_x, end_y, end_z;
  int                           errors, outstanding;

  bit [255:0]                   face_loaded = '0;
  bit [255:0]                   point_loaded = '0;
  idx_t                         last_face = '0;
  int                           idle_pct [6] = '{22, 0, 80, 22, 0, 80};

  always #5 clk = ~clk;

  silhouette_edge_extractor dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .start_i      (start),
    .busy_o       (busy),
    .kind_i       (kind),
    .slot_i       (slot),
    .coord_x_i    (coord_x),
    .coord_y_i    (coord_y),
    .coord_z_i    (coord_z),
    .face_a_i     (face_a),
    .face_b_i     (face_b),
    .point_a_i    (point_a),
    .point_b_i    (point_b),
    .edge_valid_o (edge_valid),
    .start_x_o    (start_x),
    .start_y_o    (start_y),
    .start_z_o    (start_z),
    .end_x_o      (end_x),
    .end_y_o      (end_y),
    .end_z_o      (end_z)
  );

  edge_scoreboard scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .start_i       (start),
    .busy_i        (busy),
    .kind_i        (kind),
    .slot_i        (slot),
    .coord_x_i     (coord_x),
    .coord_y_i     (coord_y),
    .coord_z_i     (coord_z),
    .face_a_i      (face_a),
    .face_b_i      (face_b),
    .point_a_i     (point_a),
    .point_b_i     (point_b),
    .edge_valid_i  (edge_valid),
    .start_x_i     (start_x),
    .start_y_i     (start_y),
    .start_z_i     (start_z),
    .end_x_i       (end_x),
    .end_y_i       (end_y),
    .end_z_i       (end_z),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  function automatic geom_req_t make_req(logic [sse_pkg::KindW-1:0] k, idx_t s,
                                         sse_pkg::coord_t x, sse_pkg::coord_t y,
                                         sse_pkg::coord_t z,
                                         idx_t fa, idx_t fb, idx_t pa, idx_t pb);
    geom_req_t r;
    r.kind = k;
    r.slot = s;
    r.x    = x;
    r.y    = y;
    r.z    = z;
    r.fa   = fa;
    r.fb   = fb;
    r.pa   = pa;
    r.pb   = pb;
    return r;
  endfunction

  function automatic sse_pkg::coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return CMIN;
      1:       return CMAX;
      2:       return '0;
      3:       return -1;
      4:       return sse_pkg::coord_t'(int'($urandom_range(0, 16)) - 8);
      default: return sse_pkg::coord_t'($urandom);
    endcase
  endfunction

  // edges only read entries that were loaded; favor the newest face for bypass
  function automatic idx_t pick_face();
    idx_t v;
    if ($urandom_range(0, 3) == 0) return last_face;
    do v = idx_t'($urandom_range(0, 255)); while (!face_loaded[v]);
    return v;
  endfunction

  function automatic idx_t pick_point();
    idx_t v;
    do v = idx_t'($urandom_range(0, 255)); while (!point_loaded[v]);
    return v;
  endfunction

  function automatic geom_req_t rand_req();
    geom_req_t r;
    int        pick;
    r = make_req(sse_pkg::KIND_FACE,
                 idx_t'($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 15)),
                 rand_coord(), rand_coord(), rand_coord(),
                 idx_t'($urandom), idx_t'($urandom), idx_t'($urandom), idx_t'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.kind = sse_pkg::KIND_FACE;
    end else if (pick < 55) begin
      r.kind = sse_pkg::KIND_POINT;
    end else if (pick < 95) begin
      r.kind = sse_pkg::KIND_EDGE;
      r.fa   = pick_face();
      r.fb   = pick_face();
      r.pa   = pick_point();
      r.pb   = pick_point();
    end else begin
      r.kind = KIND_SPARE;
    end
    return r;
  endfunction

  task automatic issue(geom_req_t r, int idle);
    while ($urandom_range(1, 100) <= idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    kind    <= r.kind;
    slot    <= r.slot;
    coord_x <= r.x;
    coord_y <= r.y;
    coord_z <= r.z;
    face_a  <= r.fa;
    face_b  <= r.fb;
    point_a <= r.pa;
    point_b <= r.pb;
    if (r.kind == sse_pkg::KIND_FACE) begin
      face_loaded[r.slot] = 1'b1;
      last_face = r.slot;
    end
    if (r.kind == sse_pkg::KIND_POINT) point_loaded[r.slot] = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_light(sse_pkg::coord_t lx, sse_pkg::coord_t ly, sse_pkg::coord_t lz);
    cfg_we    <= 1'b1;
    cfg_addr  <= sse_pkg::REG_LIGHT_X;
    cfg_wdata <= lx;
    @(posedge clk);
    cfg_addr  <= sse_pkg::REG_LIGHT_Y;
    cfg_wdata <= ly;
    @(posedge clk);
    cfg_addr  <= sse_pkg::REG_LIGHT_Z;
    cfg_wdata <= lz;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // wait for every predicted edge, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_light(CMIN, CMIN, CMIN);
    @(posedge clk);

    // three min products overflow 64 bits but stay positive
    issue(make_req(sse_pkg::KIND_FACE, 8'd0, CMIN, CMIN, CMIN, 0, 0, 0, 0), 0);
    issue(make_req(sse_pkg::KIND_FACE, 8'd255, CMAX, CMAX, CMAX, 0, 0, 0, 0), 0);
    issue(make_req(sse_pkg::KIND_FACE, 8'd1, 0, 0, 0, 0, 0, 0, 0), 0);
    // products cancel to exactly zero: unlit
    issue(make_req(sse_pkg::KIND_FACE, 8'd2, -1, 1, 0, 0, 0, 0, 0), 0);
    issue(make_req(sse_pkg::KIND_FACE, 8'd3, -1, 0, 0, 0, 0, 0, 0), 0);
    issue(make_req(sse_pkg::KIND_POINT, 8'd0, CMIN, CMIN, CMIN, 0, 0, 0, 0), 0);
    issue(make_req(sse_pkg::KIND_POINT, 8'd255, CMAX, CMAX, CMAX, 0, 0, 0, 0), 0);
    issue(make_req(sse_pkg::KIND_POINT, 8'd85, 32'sh5555_5555, -1, 1, 0, 0, 0, 0), 0);
    issue(make_req(sse_pkg::KIND_POINT, 8'd170, 32'shaaaa_aaaa, 0, CMIN, 0, 0, 0, 0), 0);
    issue(make_req(sse_pkg::KIND_EDGE, 0, 0, 0, 0, 8'd0, 8'd255, 8'd0, 8'd255), 0);
    issue(make_req(sse_pkg::KIND_EDGE, 0, 0, 0, 0, 8'd255, 8'd0, 8'd170, 8'd85), 0);
    issue(make_req(sse_pkg::KIND_EDGE, 0, 0, 0, 0, 8'd0, 8'd3, 8'd0, 8'd255), 0);
    issue(make_req(sse_pkg::KIND_EDGE, 0, 0, 0, 0, 8'd1, 8'd2, 8'd0, 8'd255), 0);
    issue(make_req(sse_pkg::KIND_EDGE, 0, 0, 0, 0, 8'd3, 8'd3, 8'd85, 8'd170), 0);
    // edge right behind the face load that it reads
    issue(make_req(sse_pkg::KIND_FACE, 8'd170, CMIN, 0, 0, 0, 0, 0, 0), 0);
    issue(make_req(sse_pkg::KIND_EDGE, 0, 0, 0, 0, 8'd1, 8'd170, 8'd0, 8'd85), 0);
    issue(make_req(sse_pkg::KIND_FACE, 8'd170, CMAX, 0, 0, 0, 0, 0, 0), 0);
    issue(make_req(sse_pkg::KIND_EDGE, 0, 0, 0, 0, 8'd170, 8'd3, 8'd255, 8'd170), 0);
    issue(make_req(sse_pkg::KIND_POINT, 8'd85, 1, 2, 3, 0, 0, 0, 0), 0);
    issue(make_req(sse_pkg::KIND_EDGE, 0, 0, 0, 0, 8'd3, 8'd1, 8'd85, 8'd0), 0);
    // unused kind must leave the point table alone
    issue(make_req(KIND_SPARE, 8'd0, CMAX, CMAX, CMAX, 8'd255, 8'd255, 8'd255, 8'd255), 0);
    issue(make_req(sse_pkg::KIND_EDGE, 0, 0, 0, 0, 8'd0, 8'd1, 8'd0, 8'd170), 0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1:       write_light(CMAX, CMAX, CMAX);
          2:       write_light(0, 0, 0);
          4:       write_light(CMIN, CMAX, rand_coord());
          default: write_light(rand_coord(), rand_coord(), rand_coord());
        endcase
        @(posedge clk);
        // flags loaded under the previous light keep their old value
        issue(make_req(sse_pkg::KIND_EDGE, 0, 0, 0, 0, 8'd0, 8'd255, 8'd0, 8'd255), 0);
      end
      repeat (ReqPerPhase) issue(rand_req(), idle_pct[ph]);
    end

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule
